FILE: hw/rtl/fcpt_pkg.sv
// Shared constants, types and the quarter-wave sine table for the
// Clarke/Park transform block. No dependencies.
package fcpt_pkg;

  // Field and stream widths
  localparam int DATA_WIDTH       = 16;
  localparam int ANGLE_W          = 16;
  localparam int NUM_IN_FIELDS    = 6;
  localparam int NUM_OUT_FIELDS   = 5;
  localparam int IN_TDATA_W       = ((NUM_IN_FIELDS * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W      = ((NUM_OUT_FIELDS * DATA_WIDTH + 7) / 8) * 8;

  // Fixed-point formats (Q1.15 trig and constants)
  localparam int FRAC             = 15;
  localparam int HALF_SHIFT       = FRAC - 1;
  localparam int SIN_W            = 16;
  localparam int K_W              = 16;
  localparam logic signed [K_W-1:0] SQRT3_HALF = 16'sd28378;

  // Sine table geometry
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int PHASE_W          = ANGLE_W - 2;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QUARTER_TURN     = 1 << PHASE_W;

  // Datapath widths
  localparam int SUM_W            = DATA_WIDTH + 2;
  localparam int DIFF_W           = DATA_WIDTH + 1;
  localparam int BETA_W           = DIFF_W + K_W;
  localparam int PROD_A_W         = SUM_W + SIN_W;
  localparam int PROD_B_W         = BETA_W + SIN_W;
  localparam int PARK_W           = PROD_B_W + 1;
  localparam int CMD_PROD_W       = DATA_WIDTH + SIN_W;
  localparam int AB_W             = CMD_PROD_W + 1;
  localparam int KBO_W            = AB_W + K_W;
  localparam int INV_W            = KBO_W + 1;

  // Pipeline depth, output register included
  localparam int PIPE_DEPTH       = 6;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SINE_TABLE_DEPTH:0][SIN_W-1:0] sin_lut_t;

  // Entry k = round(32767 * sin(pi/2 * k / DEPTH)), Q30 Taylor series
  function automatic sin_lut_t build_sin_lut();
    sin_lut_t    lut;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x   = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
      t   = x;
      sum = x;
      for (int n = 1; n <= 8; n++) begin
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - t;
        end else begin
          sum = sum + t;
        end
      end
      lut[k] = SIN_W'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
    end
    return lut;
  endfunction

  localparam sin_lut_t SIN_LUT = build_sin_lut();

endpackage

FILE: hw/rtl/fcpt_sincos.sv
// Quarter-wave sine lookup: quadrant fold, table read and sign.
// Depends on fcpt_pkg for the table and angle geometry.
module fcpt_sincos (
  input  logic [fcpt_pkg::ANGLE_W-1:0]       angle_i,
  output logic signed [fcpt_pkg::SIN_W-1:0]  value_o
);
  import fcpt_pkg::*;

  logic [1:0]               quad;
  logic [PHASE_W+IDX_W-1:0] scaled;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         sel;
  logic [SIN_W-1:0]         mag;

  // Table index from the phase within the quadrant
  always_comb begin
    quad   = angle_i[ANGLE_W-1 -: 2];
    scaled = (PHASE_W+IDX_W)'(angle_i[PHASE_W-1:0])
           * (PHASE_W+IDX_W)'(SINE_TABLE_DEPTH);
    idx    = scaled[PHASE_W +: IDX_W];
  end

  // Odd quadrants read the mirrored entry, upper half negates
  always_comb begin
    sel     = quad[0] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
    mag     = SIN_LUT[sel];
    value_o = quad[1] ? -$signed(mag) : $signed(mag);
  end

endmodule

FILE: hw/rtl/foc_clarke_park_transforms.sv
// Top level of the Clarke/Park forward and inverse transform pipeline.
// Depends on fcpt_pkg and fcpt_sincos.
//
// One transaction in gives one transaction out. The block takes a new
// transaction on every clock while the result side keeps up; the result
// passes through six register stages before it shows on out_tvalid
// (input sums, sine/cosine lookup, products, Park sums, rounding plus
// the inverse Clarke scale, output register). Empty stages close up
// under backpressure, so input is still taken while a result waits,
// until all six stages hold data. All results round half up and
// saturate to signed 16 bits. No state is kept between transactions.
module foc_clarke_park_transforms (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // phase_u_current, phase_v_current, phase_w_current, rotor_angle,
  // direct_command, quadrature_command (16 bits each, lowest first)
  input  logic [fcpt_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // direct_current, quadrature_current, phase_u_drive, phase_v_drive,
  // phase_w_drive (16 bits each, lowest first)
  output logic [fcpt_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fcpt_pkg::*;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  // Round half up by sh bits, then clamp to the signed output range
  function automatic logic signed [DATA_WIDTH-1:0] round_sat(
    input logic signed [63:0] x,
    input int unsigned        sh
  );
    logic signed [63:0] r;
    r = (x + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > SAT_HI) begin
      return DATA_WIDTH'(SAT_HI);
    end else if (r < SAT_LO) begin
      return DATA_WIDTH'(SAT_LO);
    end
    return DATA_WIDTH'(r);
  endfunction

  // Input fields
  logic signed [DATA_WIDTH-1:0] u_in;
  logic signed [DATA_WIDTH-1:0] v_in;
  logic signed [DATA_WIDTH-1:0] w_in;
  logic [ANGLE_W-1:0]           ang_in;
  logic signed [DATA_WIDTH-1:0] dc_in;
  logic signed [DATA_WIDTH-1:0] qc_in;

  assign u_in   = $signed(in_tdata[0*DATA_WIDTH +: DATA_WIDTH]);
  assign v_in   = $signed(in_tdata[1*DATA_WIDTH +: DATA_WIDTH]);
  assign w_in   = $signed(in_tdata[2*DATA_WIDTH +: DATA_WIDTH]);
  assign ang_in = in_tdata[3*DATA_WIDTH +: ANGLE_W];
  assign dc_in  = $signed(in_tdata[4*DATA_WIDTH +: DATA_WIDTH]);
  assign qc_in  = $signed(in_tdata[5*DATA_WIDTH +: DATA_WIDTH]);

  // Stage valid bits and per-stage advance
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  logic [PIPE_DEPTH-1:0] adv;

  always_comb begin
    adv[PIPE_DEPTH-1] = !vld_r[PIPE_DEPTH-1] || out_tready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[PIPE_DEPTH-1];

  // Stage 0: Clarke sums, cosine angle
  logic signed [SUM_W-1:0]      sum0_r;
  logic signed [DIFF_W-1:0]     diff0_r;
  logic [ANGLE_W-1:0]           angs0_r;
  logic [ANGLE_W-1:0]           angc0_r;
  logic signed [DATA_WIDTH-1:0] dc0_r;
  logic signed [DATA_WIDTH-1:0] qc0_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sum0_r  <= (SUM_W'(u_in) <<< 1) - SUM_W'(v_in) - SUM_W'(w_in);
      diff0_r <= DIFF_W'(v_in) - DIFF_W'(w_in);
      angs0_r <= ang_in;
      angc0_r <= ang_in + ANGLE_W'(QUARTER_TURN);
      dc0_r   <= dc_in;
      qc0_r   <= qc_in;
    end
  end

  // Stage 1: sine/cosine lookup, beta scale
  logic signed [SIN_W-1:0]      sin_val;
  logic signed [SIN_W-1:0]      cos_val;
  logic signed [SIN_W-1:0]      sin1_r;
  logic signed [SIN_W-1:0]      cos1_r;
  logic signed [BETA_W-1:0]     beta1_r;
  logic signed [SUM_W-1:0]      sum1_r;
  logic signed [DATA_WIDTH-1:0] dc1_r;
  logic signed [DATA_WIDTH-1:0] qc1_r;

  fcpt_sincos u_sin (
    .angle_i (angs0_r),
    .value_o (sin_val)
  );

  fcpt_sincos u_cos (
    .angle_i (angc0_r),
    .value_o (cos_val)
  );

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sin1_r  <= sin_val;
      cos1_r  <= cos_val;
      beta1_r <= BETA_W'(diff0_r) * BETA_W'(SQRT3_HALF);
      sum1_r  <= sum0_r;
      dc1_r   <= dc0_r;
      qc1_r   <= qc0_r;
    end
  end

  // Stage 2: Park and inverse Park products
  logic signed [PROD_A_W-1:0]   pac2_r;
  logic signed [PROD_A_W-1:0]   pas2_r;
  logic signed [PROD_B_W-1:0]   pbc2_r;
  logic signed [PROD_B_W-1:0]   pbs2_r;
  logic signed [CMD_PROD_W-1:0] dcc2_r;
  logic signed [CMD_PROD_W-1:0] dcs2_r;
  logic signed [CMD_PROD_W-1:0] qcc2_r;
  logic signed [CMD_PROD_W-1:0] qcs2_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pac2_r <= PROD_A_W'(sum1_r) * PROD_A_W'(cos1_r);
      pas2_r <= PROD_A_W'(sum1_r) * PROD_A_W'(sin1_r);
      pbc2_r <= PROD_B_W'(beta1_r) * PROD_B_W'(cos1_r);
      pbs2_r <= PROD_B_W'(beta1_r) * PROD_B_W'(sin1_r);
      dcc2_r <= CMD_PROD_W'(dc1_r) * CMD_PROD_W'(cos1_r);
      dcs2_r <= CMD_PROD_W'(dc1_r) * CMD_PROD_W'(sin1_r);
      qcc2_r <= CMD_PROD_W'(qc1_r) * CMD_PROD_W'(cos1_r);
      qcs2_r <= CMD_PROD_W'(qc1_r) * CMD_PROD_W'(sin1_r);
    end
  end

  // Stage 3: Park and inverse Park sums (alpha carries the one-half scale as a shift)
  logic signed [PARK_W-1:0] d3_r;
  logic signed [PARK_W-1:0] q3_r;
  logic signed [AB_W-1:0]   ao3_r;
  logic signed [AB_W-1:0]   bo3_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d3_r  <= (PARK_W'(pac2_r) <<< HALF_SHIFT) + PARK_W'(pbs2_r);
      q3_r  <= PARK_W'(pbc2_r) - (PARK_W'(pas2_r) <<< HALF_SHIFT);
      ao3_r <= AB_W'(dcc2_r) - AB_W'(qcs2_r);
      bo3_r <= AB_W'(dcs2_r) + AB_W'(qcc2_r);
    end
  end

  // Stage 4: forward results done, inverse Clarke scale
  logic signed [DATA_WIDTH-1:0] d4_r;
  logic signed [DATA_WIDTH-1:0] q4_r;
  logic signed [DATA_WIDTH-1:0] pu4_r;
  logic signed [KBO_W-1:0]      kbo4_r;
  logic signed [INV_W-1:0]      aoh4_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      d4_r   <= round_sat(64'(d3_r), 2 * FRAC);
      q4_r   <= round_sat(64'(q3_r), 2 * FRAC);
      pu4_r  <= round_sat(64'(ao3_r), FRAC);
      kbo4_r <= KBO_W'(bo3_r) * KBO_W'(SQRT3_HALF);
      aoh4_r <= INV_W'(ao3_r) <<< HALF_SHIFT;
    end
  end

  // Stage 5: inverse Clarke V/W, output register
  logic signed [INV_W-1:0]      pv_sum;
  logic signed [INV_W-1:0]      pw_sum;
  logic signed [DATA_WIDTH-1:0] d5_r;
  logic signed [DATA_WIDTH-1:0] q5_r;
  logic signed [DATA_WIDTH-1:0] pu5_r;
  logic signed [DATA_WIDTH-1:0] pv5_r;
  logic signed [DATA_WIDTH-1:0] pw5_r;

  assign pv_sum = INV_W'(kbo4_r) - aoh4_r;
  assign pw_sum = -INV_W'(kbo4_r) - aoh4_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      d5_r  <= d4_r;
      q5_r  <= q4_r;
      pu5_r <= pu4_r;
      pv5_r <= round_sat(64'(pv_sum), 2 * FRAC);
      pw5_r <= round_sat(64'(pw_sum), 2 * FRAC);
    end
  end

  assign out_tdata = {pw5_r, pv5_r, pu5_r, q5_r, d5_r};

endmodule

FILE: hw/rtl/fcpt_checker.sv
// Port-level checks for foc_clarke_park_transforms, bound to the top level.
// Depends on fcpt_pkg.
module fcpt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fcpt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import fcpt_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  // Transactions inside the block
  assign cnt_nxt = cnt_r + CNT_W'(in_tvalid && in_tready) - CNT_W'(out_tvalid && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != '0)
    else $error("result without a pending transaction");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PIPE_DEPTH))
    else $error("more transactions held than pipeline stages");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output side is ready");

endmodule

bind foc_clarke_park_transforms fcpt_checker u_fcpt_checker (.*);
